FILE: sv/assert_macros.svh
// Assertion macros for the RTL modules, used by the sequencer mcpid_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCPID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MCPID_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define MCPID_ASSERT(lbl, prop)
`define MCPID_NEVER(lbl, expr)
`endif
`endif

FILE: sv/mcpid_pkg.sv
// Shared constants, command and status types of the motor PID block
package mcpid_pkg;

    localparam int CHANNELS     = 4;
    localparam int WINDOW_DEPTH = 20;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int HIST_DEPTH   = CHANNELS * WINDOW_DEPTH;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int DIV_W        = 58;
    localparam int DIV_CW       = $clog2(DIV_W);

    localparam logic [1:0] REG_MODES  = 2'd0;
    localparam logic [1:0] REG_PROP   = 2'd1;
    localparam logic [1:0] REG_INT    = 2'd2;
    localparam logic [1:0] REG_DERIV  = 2'd3;

    localparam logic [1:0] MODE_MANUAL   = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_VEL,
        OP_ERR,
        OP_MUL_IE,
        OP_INTEG,
        OP_MUL_ILO,
        OP_MUL_IHI,
        OP_MUL_D,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic tick;
        logic manual;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/mcpid_ctrl.sv
// Sequencing state machine of the motor PID block
`include "assert_macros.svh"

module mcpid_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mcpid_pkg::sts_t  sts,
    output mcpid_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_RD    = 12'b0000_0000_0010,
        ST_VEL   = 12'b0000_0000_0100,
        ST_ERR   = 12'b0000_0000_1000,
        ST_MIE   = 12'b0000_0001_0000,
        ST_INTEG = 12'b0000_0010_0000,
        ST_MILO  = 12'b0000_0100_0000,
        ST_MIHI  = 12'b0000_1000_0000,
        ST_MD    = 12'b0001_0000_0000,
        ST_DINIT = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mcpid_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mcpid_pkg::OP_LOAD;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (sts.bad)
                    state_next = ST_FIN;
                else if (sts.tick)
                begin
                    cmd.op     = mcpid_pkg::OP_RD;
                    state_next = ST_VEL;
                end
                else if (sts.manual)
                    state_next = ST_FIN;
                else
                    state_next = ST_ERR;
            end
            ST_VEL:
            begin
                cmd.op     = mcpid_pkg::OP_VEL;
                state_next = sts.manual ? ST_FIN : ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = mcpid_pkg::OP_ERR;
                state_next = ST_MIE;
            end
            ST_MIE:
            begin
                cmd.op     = mcpid_pkg::OP_MUL_IE;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.op     = mcpid_pkg::OP_INTEG;
                state_next = ST_MILO;
            end
            ST_MILO:
            begin
                cmd.op     = mcpid_pkg::OP_MUL_ILO;
                state_next = ST_MIHI;
            end
            ST_MIHI:
            begin
                cmd.op     = mcpid_pkg::OP_MUL_IHI;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.op     = mcpid_pkg::OP_MUL_D;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.op     = mcpid_pkg::OP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = mcpid_pkg::OP_DIV_STEP;
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = mcpid_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `MCPID_ASSERT(a_div_exit, (state_reg == ST_DIV && sts.div_done) |=> (state_reg == ST_FIN))
    `MCPID_ASSERT(a_fin_hold, (state_reg == ST_FIN && !sts.out_free) |=> (state_reg == ST_FIN))
    `MCPID_ASSERT(a_accept_rd, (in_valid && in_ready) |=> (state_reg == ST_RD))
    `MCPID_NEVER(a_load_busy, (cmd.op == mcpid_pkg::OP_LOAD) && (state_reg != ST_IDLE))

endmodule

FILE: sv/mcpid_dp.sv
// Datapath: channel state, count history memory, shared multiplier and divider
module mcpid_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  mcpid_pkg::cmd_t  cmd,
    output mcpid_pkg::sts_t  sts,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_wdata,
    input  logic [87:0]      in_data,
    input  logic             in_tick,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [23:0]      out_data
);

    localparam int CH = mcpid_pkg::CHANNELS;
    localparam int SW = mcpid_pkg::SLOT_W;
    localparam int AW = mcpid_pkg::HIST_AW;
    localparam int DW = mcpid_pkg::DIV_W;
    localparam int CW = mcpid_pkg::DIV_CW;

    logic [7:0]  modes_reg;
    logic [63:0] kp_all_reg;
    logic [63:0] ki_all_reg;
    logic [63:0] kd_all_reg;

    logic [1:0]         ch_reg;
    logic signed [31:0] count_reg;
    logic signed [31:0] target_reg;
    logic               tick_reg;
    logic [15:0]        el_reg;

    logic [SW-1:0]      slot_reg  [CH];
    logic signed [31:0] vel_reg   [CH];
    logic signed [47:0] integ_reg [CH];
    logic signed [32:0] prev_reg  [CH];

    logic [31:0]        hist_mem  [mcpid_pkg::HIST_DEPTH];
    logic               hist_vld_reg [mcpid_pkg::HIST_DEPTH];
    logic [31:0]        rd_data_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      addr_reg;

    logic signed [32:0] err_reg;
    logic signed [51:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [DW-1:0]      dvd_reg;
    logic [15:0]        rem_reg;
    logic [CW-1:0]      cnt_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic [23:0]        out_data_reg;

    logic [1:0]         mode;
    logic               bad;
    logic [SW-1:0]      slot_cur;
    logic [SW-1:0]      slot_new;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic               wr_en;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic signed [47:0] integ_cur;
    logic signed [17:0] ma;
    logic signed [33:0] mb;
    logic signed [51:0] prod;
    logic signed [52:0] integ_sum;
    logic signed [47:0] integ_sat;
    logic signed [33:0] err_diff;
    logic signed [63:0] acc_clamp;
    logic [51:0]        prod_abs;
    logic [16:0]        rem_sh;
    logic [16:0]        rem_diff;
    logic               q_bit;
    logic signed [63:0] quot;
    logic signed [63:0] drive;
    logic [16:0]        mag;
    logic               clamped;
    logic [24:0]        duty_sum;
    logic [7:0]         duty;
    logic [7:0]         duty_fwd;
    logic [7:0]         duty_rev;

    assign mode      = modes_reg[2*ch_reg +: 2];
    assign bad       = ({1'b0, ch_reg} >= 3'(CH));
    assign kp        = kp_all_reg[16*ch_reg +: 16];
    assign ki        = ki_all_reg[16*ch_reg +: 16];
    assign kd        = kd_all_reg[16*ch_reg +: 16];
    assign integ_cur = integ_reg[ch_reg];
    assign slot_cur  = slot_reg[ch_reg];
    assign slot_new  = (slot_cur == SW'(mcpid_pkg::WINDOW_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
    assign rd_addr   = AW'(ch_reg) * AW'(mcpid_pkg::WINDOW_DEPTH) + AW'(slot_new);
    assign rd_en     = (cmd.op == mcpid_pkg::OP_RD);
    assign wr_en     = (cmd.op == mcpid_pkg::OP_VEL);
    assign err_diff  = 34'(err_reg) - 34'(prev_reg[ch_reg]);

    always_comb
    begin
        ma = 18'(kp);
        mb = 34'(err_reg);
        case (cmd.op)
            mcpid_pkg::OP_MUL_IE:
            begin
                ma = {2'b00, el_reg};
                mb = 34'(err_reg);
            end
            mcpid_pkg::OP_MUL_ILO:
            begin
                ma = 18'(ki);
                mb = {10'b0, integ_cur[23:0]};
            end
            mcpid_pkg::OP_MUL_IHI:
            begin
                ma = 18'(ki);
                mb = 34'($signed(integ_cur[47:24]));
            end
            mcpid_pkg::OP_MUL_D:
            begin
                ma = 18'(kd);
                mb = err_diff;
            end
            default:
            begin
                ma = 18'(kp);
                mb = 34'(err_reg);
            end
        endcase
    end

    assign prod = ma * mb;

    assign integ_sum = 53'(integ_cur) + 53'(prod_reg);
    always_comb
    begin
        if (integ_sum > 53'sh7FFF_FFFF_FFFF)
            integ_sat = 48'sh7FFF_FFFF_FFFF;
        else if (integ_sum < -53'sh8000_0000_0000)
            integ_sat = 48'sh8000_0000_0000;
        else
            integ_sat = integ_sum[47:0];
    end

    always_comb
    begin
        if (acc_reg > (64'sd1 <<< 54))
            acc_clamp = 64'sd1 <<< 54;
        else if (acc_reg < -(64'sd1 <<< 54))
            acc_clamp = -(64'sd1 <<< 54);
        else
            acc_clamp = acc_reg;
    end

    assign prod_abs = prod_reg[51] ? 52'(-prod_reg) : 52'(prod_reg);
    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign rem_diff = rem_sh - {1'b0, el_reg};
    assign q_bit    = (rem_sh >= {1'b0, el_reg});
    assign sts.div_done = (cnt_reg == CW'(DW - 1));

    assign quot = neg_reg ? -64'(dvd_reg) : 64'(dvd_reg);

    always_comb
    begin
        if (bad)
            drive = '0;
        else if (mode == mcpid_pkg::MODE_MANUAL)
            drive = 64'(target_reg);
        else
            drive = (acc_reg <<< 8) + quot;
    end

    always_comb
    begin
        clamped = 1'b0;
        if (drive > 64'sd65536)
        begin
            mag     = 17'd65536;
            clamped = 1'b1;
        end
        else if (drive < -64'sd65536)
        begin
            mag     = 17'd65536;
            clamped = 1'b1;
        end
        else if (drive < 0)
            mag = 17'(-drive);
        else
            mag = drive[16:0];
    end

    assign duty_sum = {mag, 8'b0} - 25'(mag) + 25'd32768;
    assign duty     = duty_sum[23:16];
    assign duty_fwd = (drive > 0) ? duty : 8'd0;
    assign duty_rev = (drive > 0) ? 8'd0 : duty;

    assign sts.bad      = bad;
    assign sts.tick     = tick_reg;
    assign sts.manual   = (mode == mcpid_pkg::MODE_MANUAL);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= hist_mem[rd_addr];
        if (wr_en)
            hist_mem[addr_reg] <= count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == mcpid_pkg::OP_LOAD)
        begin
            ch_reg     <= in_data[1:0];
            count_reg  <= in_data[33:2];
            target_reg <= in_data[65:34];
            el_reg     <= (in_data[81:66] == 16'd0) ? 16'd1 : in_data[81:66];
            tick_reg   <= in_tick;
        end
        if (rd_en)
            addr_reg <= rd_addr;
        if (cmd.op == mcpid_pkg::OP_ERR)
        begin
            if (mode == mcpid_pkg::MODE_POSITION)
                err_reg <= 33'(target_reg) - 33'(count_reg);
            else
                err_reg <= 33'(target_reg) - 33'(vel_reg[ch_reg]);
        end
        case (cmd.op)
            mcpid_pkg::OP_MUL_IE,
            mcpid_pkg::OP_INTEG,
            mcpid_pkg::OP_MUL_ILO,
            mcpid_pkg::OP_MUL_IHI,
            mcpid_pkg::OP_MUL_D:
                prod_reg <= prod;
            default:
                prod_reg <= prod_reg;
        endcase
        case (cmd.op)
            mcpid_pkg::OP_MUL_ILO:  acc_reg <= 64'(prod_reg);
            mcpid_pkg::OP_MUL_IHI:  acc_reg <= acc_reg + 64'(prod_reg);
            mcpid_pkg::OP_MUL_D:    acc_reg <= acc_reg + (64'(prod_reg) <<< 24);
            mcpid_pkg::OP_DIV_INIT: acc_reg <= acc_clamp;
            default:                acc_reg <= acc_reg;
        endcase
        if (cmd.op == mcpid_pkg::OP_DIV_INIT)
        begin
            dvd_reg <= {prod_abs[49:0], 8'b0};
            neg_reg <= prod_reg[51];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.op == mcpid_pkg::OP_DIV_STEP)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.op == mcpid_pkg::OP_FINISH)
            out_data_reg <= {5'b0, clamped, duty_rev, duty_fwd, ch_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg     <= '0;
            kp_all_reg    <= '0;
            ki_all_reg    <= '0;
            kd_all_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            for (int i = 0; i < CH; i++)
            begin
                slot_reg[i]  <= '0;
                vel_reg[i]   <= '0;
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
            for (int j = 0; j < mcpid_pkg::HIST_DEPTH; j++)
                hist_vld_reg[j] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mcpid_pkg::REG_MODES: modes_reg  <= cfg_wdata[7:0];
                    mcpid_pkg::REG_PROP:  kp_all_reg <= cfg_wdata;
                    mcpid_pkg::REG_INT:   ki_all_reg <= cfg_wdata;
                    mcpid_pkg::REG_DERIV: kd_all_reg <= cfg_wdata;
                    default:              modes_reg  <= modes_reg;
                endcase
            end
            if (rd_en)
            begin
                slot_reg[ch_reg] <= slot_new;
                rd_vld_reg       <= hist_vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                hist_vld_reg[addr_reg] <= 1'b1;
                vel_reg[ch_reg] <= count_reg - (rd_vld_reg ? rd_data_reg : 32'd0);
            end
            if (cmd.op == mcpid_pkg::OP_INTEG)
                integ_reg[ch_reg] <= integ_sat;
            if (cmd.op == mcpid_pkg::OP_MUL_D)
                prev_reg[ch_reg] <= err_reg;
            if (cmd.op == mcpid_pkg::OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: sv/multi_channel_motor_pid_top.sv
// Top level of the four-channel motor PID controller
// A control tick in a PID mode ends with the 58-bit bit-serial divider for the derivative
// term, after five passes through the shared 18x34 multiplier; manual mode skips both, and a
// window tick adds the history read and the velocity update. One tick is worked on at a time,
// and a finished result waits in the output register while the next tick is taken.
module multi_channel_motor_pid_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // channel, encoder_count, target, elapsed_us
    input  logic [0:0]  s_axis_tuser,  // window_tick
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // out_channel, duty_forward, duty_reverse, clamped
);

    mcpid_pkg::cmd_t cmd;
    mcpid_pkg::sts_t sts;

    mcpid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcpid_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_tick   (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: tb/mcpid_checker.sv
// Checker for the motor PID block: watches config and streams, predicts duties and compares
`timescale 1ns / 100ps
module mcpid_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // channel, encoder_count, target, elapsed_us
    input  logic [0:0]  s_axis_tuser,  // window_tick
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,  // out_channel, duty_forward, duty_reverse, clamped
    output int          mismatches,
    output int          outstanding
);

    localparam longint INTEG_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    localparam longint PI_BOUND   = 64'sh0040_0000_0000_0000;
    localparam longint FULL_DRIVE = 65536;

    typedef struct packed {
        logic       clamp;
        logic [7:0] rev;
        logic [7:0] fwd;
        logic [1:0] ch;
    } duty_t;

    logic [7:0]  modes;
    logic [63:0] kp_reg, ki_reg, kd_reg;
    logic [31:0] count_ring [mcpid_pkg::CHANNELS][mcpid_pkg::WINDOW_DEPTH];
    int          ring_pos [mcpid_pkg::CHANNELS];
    logic [31:0] velocity [mcpid_pkg::CHANNELS];
    longint      integral [mcpid_pkg::CHANNELS];
    longint      last_error [mcpid_pkg::CHANNELS];
    duty_t       duty_queue[$];

    function automatic duty_t compute_duty(logic [1:0] ch, logic [31:0] cnt, logic tick,
                                           logic [31:0] tgt, logic [15:0] el);
        longint e, err, integ, pi, d, drv, mag, kp, ki, kd, dv;
        logic [1:0] md;
        int s;
        duty_t r;
        e = (el == 0) ? 1 : longint'(el);
        r = '0;
        r.ch = ch;
        if (tick)
        begin
            s = ring_pos[ch] + 1;
            if (s >= mcpid_pkg::WINDOW_DEPTH) s = 0;
            ring_pos[ch] = s;
            velocity[ch] = cnt - count_ring[ch][s];
            count_ring[ch][s] = cnt;
        end
        md = modes[2*ch +: 2];
        if (md == mcpid_pkg::MODE_MANUAL)
            drv = longint'($signed(tgt));
        else
        begin
            kp = longint'($signed(kp_reg[16*ch +: 16]));
            ki = longint'($signed(ki_reg[16*ch +: 16]));
            kd = longint'($signed(kd_reg[16*ch +: 16]));
            if (md == mcpid_pkg::MODE_POSITION)
                err = longint'($signed(tgt)) - longint'($signed(cnt));
            else
                err = longint'($signed(tgt)) - longint'($signed(velocity[ch]));
            integ = integral[ch] + err * e;
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            if (integ < INTEG_MIN) integ = INTEG_MIN;
            integral[ch] = integ;
            pi = kp * err + ki * integ;
            if (pi > PI_BOUND) pi = PI_BOUND;
            if (pi < -PI_BOUND) pi = -PI_BOUND;
            d = (kd * (err - last_error[ch]) * 256) / e;
            last_error[ch] = err;
            drv = pi * 256 + d;
        end
        if (drv > FULL_DRIVE)
        begin
            drv = FULL_DRIVE;
            r.clamp = 1'b1;
        end
        if (drv < -FULL_DRIVE)
        begin
            drv = -FULL_DRIVE;
            r.clamp = 1'b1;
        end
        mag = (drv < 0) ? -drv : drv;
        dv = (mag * 255 + 32768) >>> 16;
        if (drv > 0) r.fwd = dv[7:0];
        else r.rev = dv[7:0];
        return r;
    endfunction

    assign outstanding = duty_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        duty_t want, got;
        if (!rst_n)
        begin
            modes = '0;
            kp_reg = '0;
            ki_reg = '0;
            kd_reg = '0;
            for (int c = 0; c < mcpid_pkg::CHANNELS; c++)
            begin
                ring_pos[c] = 0;
                velocity[c] = '0;
                integral[c] = 0;
                last_error[c] = 0;
                for (int k = 0; k < mcpid_pkg::WINDOW_DEPTH; k++) count_ring[c][k] = '0;
            end
            duty_queue.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mcpid_pkg::REG_MODES: modes  = cfg_wdata[7:0];
                    mcpid_pkg::REG_PROP:  kp_reg = cfg_wdata;
                    mcpid_pkg::REG_INT:   ki_reg = cfg_wdata;
                    mcpid_pkg::REG_DERIV: kd_reg = cfg_wdata;
                    default:              modes  = modes;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = duty_t'(m_axis_tdata[18:0]);
                if (duty_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: ch %0d fwd %0d rev %0d clamp %0d",
                                 got.ch, got.fwd, got.rev, got.clamp);
                end
                else
                begin
                    want = duty_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.ch, want.fwd, want.rev, want.clamp,
                                     got.ch, got.fwd, got.rev, got.clamp);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                duty_queue.push_back(compute_duty(s_axis_tdata[1:0], s_axis_tdata[33:2],
                                                  s_axis_tuser[0], s_axis_tdata[65:34],
                                                  s_axis_tdata[81:66]));
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the motor PID testbench: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int RAND_ITEMS  = 130;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          mismatches;
    int          outstanding;
    int          cycles;
    logic        quiet;
    logic        pressure_req;
    int          stall_left;
    logic [7:0]  modes;
    logic [31:0] motor_pos [mcpid_pkg::CHANNELS];

    multi_channel_motor_pid_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    mcpid_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[multi_channel_motor_pid_top] ERROR");
            $finish;
        end
    end

    // receiver: random stall after each transfer unless quiet, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            stall_left <= 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            n = stall_left;
            if (pressure_req) n = 400;
            else if (m_axis_tvalid && m_axis_tready) n = quiet ? 0 : $urandom_range(0, 8);
            else if (n > 0) n = n - 1;
            stall_left <= n;
            m_axis_tready <= (n == 0);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic configure(logic [7:0] md, logic [63:0] kp, logic [63:0] ki, logic [63:0] kd);
        write_reg(mcpid_pkg::REG_MODES, {56'd0, md});
        write_reg(mcpid_pkg::REG_PROP, kp);
        write_reg(mcpid_pkg::REG_INT, ki);
        write_reg(mcpid_pkg::REG_DERIV, kd);
        cfg_we <= 1'b0;
        modes = md;
    endtask

    task automatic drain();
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send(logic [1:0] ch, logic [31:0] cnt, logic tick, logic [31:0] tgt,
                        logic [15:0] el);
        int gap;
        logic rdy;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, el, tgt, cnt, ch};
        s_axis_tuser <= tick;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 600)) - 16'd300;
            1: return 16'($urandom_range(0, 32)) - 16'd16;
            2: return 16'($urandom_range(0, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_gains();
        return {pick_gain(), pick_gain(), pick_gain(), pick_gain()};
    endfunction

    task automatic send_random();
        logic [1:0]  ch;
        logic [1:0]  md;
        logic [31:0] cnt, tgt;
        logic [15:0] el;
        ch = 2'($urandom_range(0, 3));
        md = modes[2*ch +: 2];
        if ($urandom_range(0, 9) == 0) motor_pos[ch] = $urandom;
        else motor_pos[ch] = motor_pos[ch] + 32'($urandom_range(0, 200)) - 32'd100;
        cnt = motor_pos[ch];
        if ($urandom_range(0, 4) == 0) tgt = $urandom;
        else if (md == mcpid_pkg::MODE_MANUAL) tgt = 32'($urandom_range(0, 160000)) - 32'd80000;
        else if (md == mcpid_pkg::MODE_POSITION) tgt = cnt + 32'($urandom_range(0, 400)) - 32'd200;
        else tgt = 32'($urandom_range(0, 600)) - 32'd300;
        el = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 2000));
        send(ch, cnt, 1'($urandom), tgt, el);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        quiet = 1'b0;
        pressure_req = 1'b0;
        modes = '0;
        for (int c = 0; c < mcpid_pkg::CHANNELS; c++) motor_pos[c] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(8'h00, '0, '0, '0);
        send(2'd0, 32'h7FFF_FFFF, 1'b1, 32'd0, 16'd1);
        send(2'd1, 32'h8000_0000, 1'b0, 32'd65536, 16'd65535);
        send(2'd2, 32'd0, 1'b1, 32'd65537, 16'd1);
        send(2'd3, 32'hFFFF_FFFF, 1'b0, -32'sd65536, 16'd100);
        send(2'd0, 32'd5, 1'b0, -32'sd65537, 16'd1);
        send(2'd1, 32'd5, 1'b0, 32'd128, 16'd1);
        send(2'd2, 32'd5, 1'b0, 32'd129, 16'd1);
        send(2'd3, 32'd5, 1'b0, 32'h7FFF_FFFF, 16'd1);
        send(2'd0, 32'd5, 1'b0, 32'h8000_0000, 16'd1);
        send(2'd1, 32'd5, 1'b0, 32'hFFFF_FFFF, 16'd1);
        s_axis_tvalid <= 1'b0;
        drain();

        configure(8'hE4, {4{16'h0100}}, {4{16'h0001}}, {4{16'h0010}});
        send(2'd1, 32'd0, 1'b1, 32'd100, 16'd1);
        send(2'd1, 32'd50, 1'b0, 32'd100, 16'd65535);
        send(2'd1, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 16'd65535);
        send(2'd1, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 16'd65535);
        send(2'd1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 16'd1);
        send(2'd2, 32'd10, 1'b1, 32'd5, 16'd10);
        send(2'd2, 32'd30, 1'b1, 32'd5, 16'd10);
        send(2'd3, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 16'd1);
        send(2'd3, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 16'd1);
        send(2'd0, 32'd0, 1'b1, 32'd0, 16'd1);
        s_axis_tvalid <= 1'b0;
        drain();

        for (int ph = 2; ph < PHASES; ph++)
        begin
            if (ph == 2) configure(8'($urandom), {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
            else if (ph == 3)
                configure(8'($urandom), {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
            else if (ph == 4) configure(8'hFF, pick_gains(), pick_gains(), pick_gains());
            else configure(8'($urandom), pick_gains(), pick_gains(), pick_gains());
            quiet = (ph == 5);
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                if (ph == 4 && i == 5)
                begin
                    pressure_req <= 1'b1;
                    @(posedge clk);
                    pressure_req <= 1'b0;
                end
                send_random();
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("[multi_channel_motor_pid_top] OK");
        else
            $display("[multi_channel_motor_pid_top] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mcpid_pkg.sv
sv/mcpid_ctrl.sv
sv/mcpid_dp.sv
sv/multi_channel_motor_pid_top.sv
tb/mcpid_checker.sv
tb/testbench.sv
